>>> rtl/hbkrd_pkg.sv
// shared types, constants and microcode table for the boot keyboard report differ
// no dependencies
`default_nettype none

package hbkrd_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int MOD_BITS  = 8;
    localparam int USAGE_W   = 8;
    localparam int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int IDX_W     = $clog2((KEY_SLOTS > MOD_BITS) ? KEY_SLOTS : MOD_BITS);
    localparam int PC_W      = 3;
    localparam int IN_DATA_W = USAGE_W * (1 + KEY_SLOTS);
    localparam int IN_DATA_BYTES_W = ((IN_DATA_W + 7) / 8) * 8;

    localparam logic [USAGE_W-1:0] MOD_BASE     = 8'hE0;
    localparam logic [USAGE_W-1:0] KEY_MIN      = 8'h04;
    localparam logic [USAGE_W-1:0] KEY_MAX      = 8'h75;
    localparam logic [USAGE_W-1:0] ROLLOVER_ERR = 8'h01;

    localparam logic [IDX_W-1:0] MOD_LAST_IDX = IDX_W'(MOD_BITS - 1);
    localparam logic [IDX_W-1:0] KEY_LAST_IDX = IDX_W'(KEY_SLOTS - 1);

    typedef enum logic [2:0] {
        OP_GRAB_MOD,
        OP_GRAB_KEY,
        OP_MOD_CHG,
        OP_RELEASE,
        OP_PRESS,
        OP_END
    } t_op;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_GRAB_START,
        COND_REPORT
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  skip_to;
    } t_uword;

    typedef struct packed {
        logic             busy;
        logic             eval;
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_ctrl;

    localparam logic [PC_W-1:0] PC_MOD_CHG = 3'd2;
    localparam logic [PC_W-1:0] PC_END     = 3'd5;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            3'd0:    w = '{op: OP_GRAB_MOD, cond: COND_GRAB_START, skip_to: PC_MOD_CHG};
            3'd1:    w = '{op: OP_GRAB_KEY, cond: COND_GRAB_START, skip_to: PC_MOD_CHG};
            3'd2:    w = '{op: OP_MOD_CHG,  cond: COND_REPORT,     skip_to: PC_END};
            3'd3:    w = '{op: OP_RELEASE,  cond: COND_REPORT,     skip_to: PC_END};
            3'd4:    w = '{op: OP_PRESS,    cond: COND_REPORT,     skip_to: PC_END};
            default: w = '{op: OP_END,      cond: COND_ALWAYS,     skip_to: PC_END};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hbkrd_seq.sv
// microcode sequencer: step counter, slot/bit index and conditional skips
// depends on hbkrd_pkg
`default_nettype none

module hbkrd_seq
    import hbkrd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_stall,
    input  wire logic i_grab_start,
    input  wire logic i_rollover,
    output t_ctrl     o_ctrl
);

    logic [PC_W-1:0]  r_pc;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;
    t_uword           w;
    logic             cond_ok;
    logic [IDX_W-1:0] last_idx;

    always_comb begin
        w = ucode(r_pc);
        case (w.cond)
            COND_ALWAYS:     cond_ok = 1'b1;
            COND_GRAB_START: cond_ok = i_grab_start;
            COND_REPORT:     cond_ok = !i_rollover;
            default:         cond_ok = 1'b0;
        endcase
        case (w.op)
            OP_GRAB_MOD, OP_MOD_CHG: last_idx = MOD_LAST_IDX;
            default:                 last_idx = KEY_LAST_IDX;
        endcase
        o_ctrl.busy = r_busy;
        o_ctrl.eval = r_busy && (w.op != OP_END) && cond_ok;
        o_ctrl.op   = w.op;
        o_ctrl.idx  = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
            r_idx  <= '0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
                r_idx  <= '0;
            end
        end else if (!i_stall) begin
            if (w.op == OP_END) begin
                r_busy <= 1'b0;
            end else if (!cond_ok) begin
                r_pc  <= w.skip_to;
                r_idx <= '0;
            end else if (r_idx == last_idx) begin
                r_pc  <= r_pc + 1'b1;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/hid_boot_keyboard_report_differ_top.sv
// boot keyboard report differ: report registers, event datapath, output stage
// depends on hbkrd_pkg and hbkrd_seq
// an event waits in a one-entry hold until the next event or the end step before it
// reaches the registered output; output stalls hold the steps
// a report runs grab steps over the 8 modifier bits and 6 key slots, skipped unless grab
// starts, then report steps over 8 + 6 + 6 indices, skipped on rollover, then one end step
// synchronous active-low reset clears held reports, grab flag and all control state
`default_nettype none

module hid_boot_keyboard_report_differ_top
    import hbkrd_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [IN_DATA_BYTES_W-1:0] i_s_axis_tdata,  // modifier_bits, key_slot_0..5
    input  wire logic                       i_s_axis_tuser,  // grab_active
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic [USAGE_W-1:0]              o_m_axis_tdata,  // key_usage
    output logic [2:0]                      o_m_axis_tuser,  // pressed, to_queue, to_console
    output logic                            o_m_axis_tlast   // last_event
);

    typedef struct packed {
        logic [USAGE_W-1:0] usage;
        logic               down;
        logic               queue;
        logic               console;
    } t_event;

    logic [MOD_BITS-1:0] r_new_mods;
    logic [USAGE_W-1:0]  r_new_keys [KEY_SLOTS];
    logic [MOD_BITS-1:0] r_prev_mods;
    logic [USAGE_W-1:0]  r_prev_keys [KEY_SLOTS];
    logic                r_grab_seen;
    logic                r_grab_start;
    logic                r_grabbed;
    logic                r_rollover;

    t_event              r_hold;
    logic                r_hold_valid;
    t_event              r_out;
    logic                r_out_last;
    logic                r_out_valid;

    t_ctrl               ctrl;
    logic                accept;
    logic                out_free;
    logic                stall;
    logic                at_end;
    logic                done;
    logic [SLOT_W-1:0]   slot;
    logic [USAGE_W-1:0]  prev_u;
    logic [USAGE_W-1:0]  new_u;
    logic                prev_in_new;
    logic                new_in_prev;
    t_event              cand;
    logic                cand_valid;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !ctrl.busy;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign at_end          = ctrl.busy && (ctrl.op == OP_END);
    assign stall           = r_hold_valid && !out_free
                             && ((ctrl.eval && cand_valid) || at_end);
    assign done            = at_end && !stall;

    hbkrd_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (accept),
        .i_stall      (stall),
        .i_grab_start (r_grab_start),
        .i_rollover   (r_rollover),
        .o_ctrl       (ctrl)
    );

    // candidate event for the current step and index
    always_comb begin
        slot        = ctrl.idx[SLOT_W-1:0];
        prev_u      = r_prev_keys[slot];
        new_u       = r_new_keys[slot];
        prev_in_new = 1'b0;
        new_in_prev = 1'b0;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            if (r_new_keys[k] == prev_u) prev_in_new = 1'b1;
            if (r_prev_keys[k] == new_u) new_in_prev = 1'b1;
        end
        cand.usage   = prev_u;
        cand.down    = 1'b0;
        cand.queue   = 1'b1;
        cand.console = !r_grabbed;
        cand_valid   = 1'b0;
        case (ctrl.op)
            OP_GRAB_MOD: begin
                cand.usage   = MOD_BASE + USAGE_W'(ctrl.idx);
                cand.queue   = 1'b0;
                cand.console = 1'b1;
                cand_valid   = r_prev_mods[ctrl.idx];
            end
            OP_GRAB_KEY: begin
                cand.queue   = 1'b0;
                cand.console = 1'b1;
                cand_valid   = (prev_u >= KEY_MIN) && (prev_u <= KEY_MAX);
            end
            OP_MOD_CHG: begin
                cand.usage = MOD_BASE + USAGE_W'(ctrl.idx);
                cand.down  = r_new_mods[ctrl.idx];
                cand_valid = r_new_mods[ctrl.idx] ^ r_prev_mods[ctrl.idx];
            end
            OP_RELEASE: begin
                cand_valid = (prev_u >= KEY_MIN) && (prev_u <= KEY_MAX) && !prev_in_new;
            end
            OP_PRESS: begin
                cand.usage = new_u;
                cand.down  = 1'b1;
                cand_valid = (new_u >= KEY_MIN) && (new_u <= KEY_MAX) && !new_in_prev;
            end
            default: begin
                cand_valid = 1'b0;
            end
        endcase
    end

    // report registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mods  <= '0;
            r_grab_seen  <= 1'b0;
            r_grab_start <= 1'b0;
            r_grabbed    <= 1'b0;
            r_rollover   <= 1'b0;
            for (int k = 0; k < KEY_SLOTS; k++) begin
                r_prev_keys[k] <= '0;
            end
        end else begin
            if (accept) begin
                r_new_mods   <= i_s_axis_tdata[MOD_BITS-1:0];
                r_grab_start <= i_s_axis_tuser && !r_grab_seen;
                r_grab_seen  <= i_s_axis_tuser;
                r_grabbed    <= i_s_axis_tuser;
                r_rollover   <= (i_s_axis_tdata[MOD_BITS +: USAGE_W] == ROLLOVER_ERR);
                for (int k = 0; k < KEY_SLOTS; k++) begin
                    r_new_keys[k] <= i_s_axis_tdata[MOD_BITS + k*USAGE_W +: USAGE_W];
                end
            end
            if (done) begin
                r_prev_mods <= r_new_mods;
                for (int k = 0; k < KEY_SLOTS; k++) begin
                    r_prev_keys[k] <= r_new_keys[k];
                end
            end
        end
    end

    // one-event hold so the final event of a report can carry tlast
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (ctrl.eval && cand_valid && !stall) begin
                r_hold       <= cand;
                r_hold_valid <= 1'b1;
                if (r_hold_valid) begin
                    r_out       <= r_hold;
                    r_out_last  <= 1'b0;
                    r_out_valid <= 1'b1;
                end else if (i_m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
            end else if (at_end && r_hold_valid && !stall) begin
                r_hold_valid <= 1'b0;
                r_out        <= r_hold;
                r_out_last   <= 1'b1;
                r_out_valid  <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.usage;
    assign o_m_axis_tuser  = {r_out.console, r_out.queue, r_out.down};
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> rtl/hbkrd_checker.sv
// port-level checks for the boot keyboard report differ, bound to the top level
// depends on hbkrd_pkg
`default_nettype none

module hbkrd_checker
    import hbkrd_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_s_axis_tvalid,
    input wire logic                       o_s_axis_tready,
    input wire logic                       o_m_axis_tvalid,
    input wire logic                       i_m_axis_tready,
    input wire logic [USAGE_W-1:0]         o_m_axis_tdata,
    input wire logic [2:0]                 o_m_axis_tuser,
    input wire logic                       o_m_axis_tlast
);

    // one report at a time
    a_one_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("report taken while previous one in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
         && $stable(o_m_axis_tlast)))
        else $error("stalled event changed");

    // console-only events are grab-start releases
    a_console_only_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[1]) |-> (!o_m_axis_tuser[0] && o_m_axis_tuser[2]))
        else $error("console-only event is not a release");

    // presses are keys in range or modifiers
    a_press_usage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
        ((o_m_axis_tdata >= KEY_MIN && o_m_axis_tdata <= KEY_MAX)
         || o_m_axis_tdata >= MOD_BASE))
        else $error("press of usage outside key or modifier range");

endmodule

bind hid_boot_keyboard_report_differ_top hbkrd_checker u_hbkrd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

>>> dv/tb_hid_boot_keyboard_report_differ_top.sv
// testbench for hid_boot_keyboard_report_differ_top: streams boot keyboard reports and checks
// every key event against an in-bench prediction of the report differ
// depends on hbkrd_pkg and the differ rtl
module tb_hid_boot_keyboard_report_differ_top;
    import hbkrd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REPORTS = 350;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_SHOWN      = 10;

    typedef logic [KEY_SLOTS-1:0][USAGE_W-1:0] t_slots;

    typedef struct packed {
        logic                grab;
        t_slots              keys;
        logic [MOD_BITS-1:0] mods;
    } t_report;

    typedef struct packed {
        logic [USAGE_W-1:0] usage;
        logic               pressed;
        logic               to_queue;
        logic               to_console;
        logic               last;
    } t_event;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_s_axis_tvalid = 1'b0;
    logic                       o_s_axis_tready;
    logic [IN_DATA_BYTES_W-1:0] i_s_axis_tdata = '0;
    logic                       i_s_axis_tuser = 1'b0;
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready = 1'b0;
    logic [USAGE_W-1:0]         o_m_axis_tdata;
    logic [2:0]                 o_m_axis_tuser;
    logic                       o_m_axis_tlast;

    t_report pending_reports[$];
    t_event  expected_events[$];

    logic [MOD_BITS-1:0] held_mods = '0;
    t_slots              held_keys = '0;
    logic                grab_was = 1'b0;

    logic in_taken = 1'b0;
    int   idle_cycles = 0;
    int   mismatch_count = 0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   rx_mode = 0;
    int   rx_left = 0;

    hid_boot_keyboard_report_differ_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_slots slots(input logic [7:0] s0, s1, s2, s3, s4, s5);
        return {s5, s4, s3, s2, s1, s0};
    endfunction

    function automatic bit is_key(input logic [USAGE_W-1:0] u);
        return (u >= KEY_MIN) && (u <= KEY_MAX);
    endfunction

    function automatic bit slot_has(input t_slots keys, input logic [USAGE_W-1:0] u);
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (keys[i] == u) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_event key_event(input logic [USAGE_W-1:0] u,
                                         input logic down, queue, console);
        return '{usage: u, pressed: down, to_queue: queue, to_console: console, last: 1'b0};
    endfunction

    // diff one report against the held one and queue the events it causes
    function automatic void predict_events(input t_report r);
        t_event              evs[$];
        logic                console;
        logic [MOD_BITS-1:0] changed;
        if (r.grab && !grab_was) begin
            for (int b = 0; b < MOD_BITS; b++) begin
                if (held_mods[b])
                    evs.push_back(key_event(USAGE_W'(MOD_BASE + b), 1'b0, 1'b0, 1'b1));
            end
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (is_key(held_keys[i]))
                    evs.push_back(key_event(held_keys[i], 1'b0, 1'b0, 1'b1));
            end
        end
        grab_was = r.grab;
        console = !r.grab;
        if (r.keys[0] != ROLLOVER_ERR) begin
            changed = r.mods ^ held_mods;
            for (int b = 0; b < MOD_BITS; b++) begin
                if (changed[b])
                    evs.push_back(key_event(USAGE_W'(MOD_BASE + b), r.mods[b], 1'b1, console));
            end
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (is_key(held_keys[i]) && !slot_has(r.keys, held_keys[i]))
                    evs.push_back(key_event(held_keys[i], 1'b0, 1'b1, console));
            end
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (is_key(r.keys[i]) && !slot_has(held_keys, r.keys[i]))
                    evs.push_back(key_event(r.keys[i], 1'b1, 1'b1, console));
            end
        end
        held_mods = r.mods;
        held_keys = r.keys;
        if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
        foreach (evs[i]) expected_events.push_back(evs[i]);
    endfunction

    task automatic log_mismatch(input string what, input t_event want, input t_event got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%0t: %s: expected %h p%b q%b c%b l%b, got %h p%b q%b c%b l%b",
                     $realtime, what, want.usage, want.pressed, want.to_queue, want.to_console,
                     want.last, got.usage, got.pressed, got.to_queue, got.to_console, got.last);
    endtask

    // report driver: bursts with random gaps
    always @(negedge i_clk) begin : report_driver
        t_report r;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_taken) begin
            if (gap_left > 0) begin
                i_s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_reports.size() > 0) begin
                r = pending_reports.pop_front();
                i_s_axis_tdata  <= {r.keys, r.mods};
                i_s_axis_tuser  <= r.grab;
                i_s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // event receiver: always ready, random, or mostly stalled, switching modes
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(20, 120);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            default: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin : event_monitor
        t_event got;
        t_event want;
        logic   in_fire;
        logic   out_fire;
        if (!i_rst_n) begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_fire  = i_s_axis_tvalid && o_s_axis_tready;
            out_fire = o_m_axis_tvalid && i_m_axis_tready;
            if (in_fire)
                predict_events('{grab: i_s_axis_tuser,
                                 keys: i_s_axis_tdata[IN_DATA_BYTES_W-1:MOD_BITS],
                                 mods: i_s_axis_tdata[MOD_BITS-1:0]});
            if (out_fire) begin
                got = '{usage: o_m_axis_tdata, pressed: o_m_axis_tuser[0],
                        to_queue: o_m_axis_tuser[1], to_console: o_m_axis_tuser[2],
                        last: o_m_axis_tlast};
                if (expected_events.size() == 0) begin
                    log_mismatch("unexpected event", '0, got);
                end else begin
                    want = expected_events.pop_front();
                    if (got != want) log_mismatch("event mismatch", want, got);
                end
            end
            in_taken    <= in_fire;
            idle_cycles <= (in_fire || out_fire) ? 0 : idle_cycles + 1;
        end
    end

    task automatic add_report(input logic [7:0] mods, input t_slots keys, input logic grab);
        pending_reports.push_back('{grab: grab, keys: keys, mods: mods});
    endtask

    initial begin : stimulus
        t_report cur;
        t_report r;
        int      kind;

        // directed reports
        add_report(8'h00, slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        add_report(8'hFF, slots(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09), 1'b0);
        add_report(8'h00, slots(8'h75, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        add_report(8'h00, slots(8'h76, 8'hFF, 8'h80, 8'hE0, 8'h75, 8'h00), 1'b0);
        add_report(8'h00, slots(8'h02, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        add_report(8'h00, slots(8'h10, 8'h10, 8'h10, 8'h00, 8'h00, 8'h00), 1'b0);
        add_report(8'hA5, slots(8'h04, 8'h75, 8'h76, 8'h03, 8'h10, 8'h10), 1'b0);
        add_report(8'hA5, slots(8'h04, 8'h75, 8'h76, 8'h03, 8'h10, 8'h10), 1'b1);
        add_report(8'h5A, slots(8'h20, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
        add_report(8'h5A, slots(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01), 1'b1);
        add_report(8'h00, slots(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        add_report(8'h03, slots(8'h30, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        add_report(8'h03, slots(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01), 1'b1);
        add_report(8'h00, slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        add_report(8'hFF, slots(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09), 1'b0);
        add_report(8'h00, slots(8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F), 1'b1);
        add_report(8'hFF, slots(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1);
        add_report(8'h00, slots(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);

        // random reports, mostly plausible typing with some rollover and noise
        cur = pending_reports[pending_reports.size()-1];
        for (int n = 0; n < RANDOM_REPORTS; n++) begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 11) == 0) cur.grab = ~cur.grab;
            if (kind < 75) begin
                if ($urandom_range(0, 2) == 0) cur.mods ^= MOD_BITS'(1 << $urandom_range(0, 7));
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: cur.keys[i] = 8'h00;
                            3:       cur.keys[i] = 8'($urandom_range(1, 3));
                            4:       cur.keys[i] = 8'($urandom_range(KEY_MAX + 1, 8'hFF));
                            default: cur.keys[i] = 8'($urandom_range(KEY_MIN, KEY_MAX));
                        endcase
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    cur.keys[$urandom_range(0, KEY_SLOTS-1)] =
                        cur.keys[$urandom_range(0, KEY_SLOTS-1)];
                if (cur.keys[0] == ROLLOVER_ERR) cur.keys[0] = 8'h00;
                r = cur;
            end else if (kind < 87) begin
                r = cur;
                r.mods = 8'($urandom);
                for (int i = 0; i < KEY_SLOTS; i++)
                    r.keys[i] = ($urandom_range(0, 1) == 0) ? ROLLOVER_ERR : 8'($urandom);
                r.keys[0] = ROLLOVER_ERR;
            end else begin
                r.mods = 8'($urandom);
                r.keys = 48'({$urandom, $urandom});
                r.grab = 1'($urandom_range(0, 1));
                cur = r;
            end
            pending_reports.push_back(r);
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
            #1;
        end while ((pending_reports.size() != 0 || i_s_axis_tvalid || expected_events.size() != 0)
                   && idle_cycles < IDLE_LIMIT);

        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            #1;
            if (mismatch_count == 0 && expected_events.size() == 0) begin
                $display("Testbench completed without errors");
            end else begin
                $display("Testbench completed WITH ERRORS");
            end
        end
        $finish;
    end

endmodule
